### hw/rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, register indexes and arithmetic constants of the
// error-diffusion dither core.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

  // channel and error widths
  localparam int PIX_W   = 8;                  // one color channel
  localparam int CH_N    = 3;                  // red, green, blue
  localparam int ERR_W   = 11;                 // stored error per channel
  localparam int EXT_W   = 12;                 // working width of quantization error
  localparam int ENTRY_W = CH_N * ERR_W;       // one row store entry
  localparam int BUS_W   = CH_N * PIX_W;       // tdata width of both channels

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LV_W       = 9;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int STEP_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [LV_W-1:0]    LV_RESET     = 9'd1;
  localparam logic [LV_W-1:0]    LV_MAX       = 9'd256;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 8'd255;   // 255 div 1

  // corrected value saturation bounds
  localparam int V_MIN = -512;
  localparam int V_MAX = 767;

  // shared multiplier operands
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int Q_W     = 10;                 // rounded quotient
  // floor(m / 255) == (m * RCP_255) >> RCP_SHIFT for all m below 2^18
  localparam int RCP_SHIFT = 26;
  localparam logic [MUL_B_W-1:0] RCP_255 = 19'd263173;
  localparam logic [MUL_A_W-1:0] ROUND_BIAS = 18'd127;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [EXT_W-1:0] ext_t;
  typedef logic [ENTRY_W-1:0]      entry_t;

  // request to the step divider
  typedef struct packed {
    logic            start;
    logic [LV_W-1:0] lv;
  } div_req_t;

  // e * k / 16, truncated toward zero
  function automatic err_t share16(input ext_t e, input logic [2:0] k);
    logic signed [15:0] p;
    logic signed [15:0] t;
    begin
      p = 16'(e) * $signed({13'd0, k});
      if (p < 0) begin
        p = p + 16'sd15;
      end
      t = p >>> 4;
      return t[ERR_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/floyd_steinberg_dither_core.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_core
// Error-diffusion dither of an RGB raster stream with one shared multiplier
// stepped by a small sequencer, and a row error store in block memory.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake             payload
//   in_       in    in_tvalid/in_tready   in_tdata: red, green, blue
//   out_      out   out_tvalid/out_tready out_tdata: red, green, blue; tlast
//   cfg_      in    cfg_wr_en             cfg_addr, cfg_wdata
//
// a pixel is taken on in_ and then worked per channel in turn (sum, three
// multiplier passes, error spread), followed by up to two row store writes and
// a hand-off to the output register; in_tready stays low until it is finished.
// a levels write starts a step division, in_tready stays low meanwhile.
// reset is synchronous on rst_n; the row store has no reset, a fill count marks
// the entries written in the current frame. a stalled output holds one result
// and the core keeps taking the next pixel until that one is finished.
//
`default_nettype none

module floyd_steinberg_dither_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // slave side
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [fsd_pkg::BUS_W-1:0]         in_tdata,   // red_in, green_in, blue_in
  // master side
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [fsd_pkg::BUS_W-1:0]              out_tdata,  // red_out, green_out, blue_out
  output logic                                   out_tlast,  // frame_end
  // configuration writes
  input  wire logic                              cfg_wr_en,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fsd_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
  localparam int FW = $clog2(MAX_WIDTH + 1);                      // fill count
  localparam int CW = (XW + 1 > IMG_W_W) ? XW + 1 : IMG_W_W;      // column compares
  localparam int RW = IMG_H_W + 1;                                // row compares

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_MUL_LV   = 4'd2;
  localparam logic [3:0] S_MUL_RCP  = 4'd3;
  localparam logic [3:0] S_MUL_STEP = 4'd4;
  localparam logic [3:0] S_ERR      = 4'd5;
  localparam logic [3:0] S_WR_LEFT  = 4'd6;
  localparam logic [3:0] S_WR_HERE  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  localparam logic [1:0] CH_LAST = 2'(CH_N - 1);

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [LV_W-1:0]     lv_r;
  logic [IMG_W_W-1:0]  width_r;
  logic [IMG_H_W-1:0]  height_r;
  logic [XW-1:0]       col_r;
  logic [IMG_H_W-1:0]  row_r;
  logic [FW-1:0]       fill_r;
  logic                out_valid_r, out_valid_nxt;

  // per pixel payload
  logic [PIX_W-1:0]    pix_r [CH_N];
  err_t                rc_r  [CH_N];     // carry to the right
  err_t                bp0_r [CH_N];     // pending below sum, column x-1 side
  err_t                bp1_r [CH_N];     // pending below sum, column x side
  err_t                wl_r  [CH_N];     // entry for column x-1
  logic [PIX_W-1:0]    res_r [CH_N];
  logic [XW-1:0]       x_r;
  logic                last_col_r;
  logic                last_row_r;
  logic                st_valid_r;

  // channel datapath registers
  err_t                v_r;
  logic                vneg_r;
  logic [9:0]          vmag_r;
  logic [MUL_A_W-1:0]  m_r;
  logic [Q_W-1:0]      r_r;
  ext_t                q_r;

  // output register
  logic [BUS_W-1:0]    out_data_r;
  logic                out_last_r;

  // row error store
  entry_t              mem [MAX_WIDTH];
  entry_t              rd_q;
  logic                mem_we;
  logic [XW-1:0]       mem_wa;
  entry_t              mem_wd;

  // step divider
  div_req_t            div_req;
  logic                div_busy;
  logic [STEP_W-1:0]   step;

  logic                accept;
  logic                load_out;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !div_busy;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------- config
  logic [LV_W-1:0] lv_wr;

  // levels zero acts as one, above 256 as 256
  always_comb begin
    lv_wr = cfg_wdata[LV_W-1:0];
    if (lv_wr == '0) begin
      lv_wr = LV_RESET;
    end else if (lv_wr > LV_MAX) begin
      lv_wr = LV_MAX;
    end
  end

  assign div_req.start = cfg_wr_en && (cfg_addr == CFG_LEVELS);
  assign div_req.lv    = lv_wr;

  fsd_step_div u_step_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .step  (step)
  );

  // ---------------------------------------------------------- raster position
  logic [CW-1:0] w_lim;
  logic          last_col_c;
  logic          last_row_c;
  logic          frame_start_c;

  // width above the store depth acts as the depth; width zero needs no case
  assign w_lim         = (CW'(width_r) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_r);
  assign last_col_c    = (CW'(col_r) + CW'(1)) >= w_lim;
  assign last_row_c    = (RW'(row_r) + RW'(1)) >= RW'(height_r);
  assign frame_start_c = (col_r == '0) && (row_r == '0);

  // ------------------------------------------------------------ shared unit
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_LV: begin
        mul_a = MUL_A_W'(vmag_r);
        mul_b = MUL_B_W'(lv_r);
      end
      S_MUL_RCP: begin
        mul_a = m_r;
        mul_b = RCP_255;
      end
      S_MUL_STEP: begin
        mul_a = MUL_A_W'(r_r);
        mul_b = MUL_B_W'(step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // ------------------------------------------------------- channel arithmetic
  err_t               st_w [CH_N];
  err_t               st_sel;
  logic signed [12:0] sum_c;
  err_t               v_sat;
  ext_t               qmag_c;
  ext_t               e_c;
  err_t               s7_c, s3_c, s5_c, s1_c;
  logic [PIX_W-1:0]   res_c;

  always_comb begin
    for (int i = 0; i < CH_N; i++) begin
      st_w[i] = rd_q[i*ERR_W +: ERR_W];
    end
  end

  // entries outside the written prefix of this frame read as zero
  assign st_sel = st_valid_r ? st_w[ch_r] : '0;
  assign sum_c  = $signed({5'd0, pix_r[ch_r]}) + 13'(rc_r[ch_r]) + 13'(st_sel);

  always_comb begin
    if (sum_c < 13'(V_MIN)) begin
      v_sat = err_t'(V_MIN);
    end else if (sum_c > 13'(V_MAX)) begin
      v_sat = err_t'(V_MAX);
    end else begin
      v_sat = sum_c[ERR_W-1:0];
    end
  end

  assign qmag_c = $signed({1'b0, prod[EXT_W-2:0]});
  assign e_c    = 12'(v_r) - q_r;

  // shares that fall outside the image are dropped
  assign s7_c = last_col_r                          ? '0 : share16(e_c, 3'd7);
  assign s3_c = (last_row_r || (x_r == '0))         ? '0 : share16(e_c, 3'd3);
  assign s5_c = last_row_r                          ? '0 : share16(e_c, 3'd5);
  assign s1_c = (last_row_r || last_col_r)          ? '0 : share16(e_c, 3'd1);

  // output clamp only, the error keeps the unclamped level
  always_comb begin
    if (q_r < 0) begin
      res_c = '0;
    end else if (q_r > 12'sd255) begin
      res_c = 8'd255;
    end else begin
      res_c = q_r[PIX_W-1:0];
    end
  end

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SUM;
          ch_nxt    = '0;
        end
      end
      S_SUM:      state_nxt = S_MUL_LV;
      S_MUL_LV:   state_nxt = S_MUL_RCP;
      S_MUL_RCP:  state_nxt = S_MUL_STEP;
      S_MUL_STEP: state_nxt = S_ERR;
      S_ERR: begin
        if (ch_r == CH_LAST) begin
          ch_nxt = '0;
          if (x_r != '0) begin
            state_nxt = S_WR_LEFT;
          end else if (last_col_r) begin
            state_nxt = S_WR_HERE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_SUM;
        end
      end
      S_WR_LEFT:  state_nxt = last_col_r ? S_WR_HERE : S_DONE;
      S_WR_HERE:  state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------- row store port
  logic [FW-1:0] wa_next;

  assign mem_we  = (state_r == S_WR_LEFT) || (state_r == S_WR_HERE);
  assign mem_wa  = (state_r == S_WR_LEFT) ? (x_r - XW'(1)) : x_r;
  assign wa_next = FW'(mem_wa) + FW'(1);

  always_comb begin
    for (int i = 0; i < CH_N; i++) begin
      mem_wd[i*ERR_W +: ERR_W] = (state_r == S_WR_LEFT) ? wl_r[i] : bp0_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= mem[col_r];
    end
  end

  // ------------------------------------------------------------ control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      lv_r        <= LV_RESET;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_LEVELS: lv_r     <= lv_wr;
          CFG_WIDTH:  width_r  <= cfg_wdata[IMG_W_W-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[IMG_H_W-1:0];
          default:    ;
        endcase
      end
      if (accept) begin
        if (last_col_c) begin
          col_r <= '0;
          row_r <= last_row_c ? '0 : row_r + IMG_H_W'(1);
        end else begin
          col_r <= col_r + XW'(1);
        end
        // first pixel of a frame empties the store
        if (frame_start_c) begin
          fill_r <= '0;
        end
      end else if (mem_we && (wa_next > fill_r)) begin
        fill_r <= wa_next;
      end
    end
  end

  // ------------------------------------------------------------ payload regs
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CH_N; i++) begin
        pix_r[i] <= in_tdata[i*PIX_W +: PIX_W];
      end
      x_r        <= col_r;
      last_col_r <= last_col_c;
      last_row_r <= last_row_c;
      st_valid_r <= !frame_start_c && (CW'(col_r) < CW'(fill_r));
      // row start: carry and pending sums begin at zero
      if (col_r == '0) begin
        for (int i = 0; i < CH_N; i++) begin
          rc_r[i]  <= '0;
          bp0_r[i] <= '0;
          bp1_r[i] <= '0;
        end
      end
    end

    case (state_r)
      S_SUM: begin
        v_r    <= v_sat;
        vneg_r <= v_sat[ERR_W-1];
        vmag_r <= v_sat[ERR_W-1] ? 10'(-v_sat) : v_sat[9:0];
      end
      S_MUL_LV: begin
        m_r <= prod[MUL_A_W-1:0] + ROUND_BIAS;
      end
      S_MUL_RCP: begin
        r_r <= prod[RCP_SHIFT+Q_W-1:RCP_SHIFT];
      end
      S_MUL_STEP: begin
        q_r <= vneg_r ? -qmag_c : qmag_c;
      end
      S_ERR: begin
        rc_r[ch_r]  <= s7_c;
        wl_r[ch_r]  <= bp0_r[ch_r] + s3_c;
        bp0_r[ch_r] <= bp1_r[ch_r] + s5_c;
        bp1_r[ch_r] <= s1_c;
        res_r[ch_r] <= res_c;
      end
      default: ;
    endcase

    if (load_out) begin
      for (int i = 0; i < CH_N; i++) begin
        out_data_r[i*PIX_W +: PIX_W] <= res_r[i];
      end
      out_last_r <= last_col_r && last_row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // -------------------------------------------------------------- assertions
  // a pixel transaction closes the input until the pixel is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while a pixel is in work");

  // the store write at the own column happens on the last column only
  a_wr_here_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_HERE) |-> last_col_r)
    else $error("row store written at own column off the row end");

  // no write to the left of column zero
  a_wr_left_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_LEFT) |-> (x_r != '0))
    else $error("row store written left of column zero");

  // a stalled result is never overwritten by the next one
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && !out_tready) |=>
      ((state_r == S_DONE) && $stable(out_data_r)))
    else $error("pending result overwritten");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(MAX_WIDTH) >= fill_r)
    else $error("fill count beyond store depth");

endmodule

`default_nettype wire

### hw/rtl/fsd_step_div.sv
// ----------------------------------------------------------------------------
// fsd_step_div
// Restoring divider giving the quantizer step 255 div levels, one quotient
// bit per cycle after a levels write.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_step_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fsd_pkg::div_req_t             req,
  output logic                               busy,
  output logic [fsd_pkg::STEP_W-1:0]         step
);
  import fsd_pkg::*;

  logic                busy_r, busy_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [LV_W-1:0]     lv_r;
  logic [STEP_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   quo_r, quo_nxt;
  logic [LV_W-1:0]     trial;
  logic                fits;
  logic [LV_W-1:0]     diff;

  // dividend is all ones, so every shifted-in bit is a one
  assign trial = {rem_r, 1'b1};
  assign fits  = (trial >= lv_r);
  assign diff  = trial - lv_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd7;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_nxt = {quo_r[STEP_W-2:0], fits};
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= STEP_RESET;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      quo_r  <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (req.start) begin
      lv_r <= req.lv;
    end
  end

  assign busy = busy_r;
  assign step = quo_r;

endmodule

`default_nettype wire

### bench/floyd_steinberg_dither_core_tb.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_core_tb
// Self-checking bench for the error-diffusion dither core. Pixels are driven
// on the in_ stream with random idle bursts. A behavioral error-diffusion
// model runs on every accepted pixel and queues the dithered pixel it
// predicts. The out_ stream is checked field by field against that queue.
// The image size and the levels register are changed between phases,
// sometimes in the middle of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module floyd_steinberg_dither_core_tb;
  import fsd_pkg::*;

  localparam int MAX_WIDTH   = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD   = 300;      // receiver hold-off, fills the core
  localparam int TARGET_PIX  = 450;
  localparam int CALM_PIX    = 380;      // from here on nobody idles
  // the one register index the core does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one dithered pixel as it should leave the core
  typedef struct packed {
    logic             frame_end;
    logic [BUS_W-1:0] rgb;               // red, green, blue from the lowest bit up
  } dithered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BUS_W-1:0]      in_tdata = '0;  // red_in, green_in, blue_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BUS_W-1:0]      out_tdata;      // red_out, green_out, blue_out
  logic                  out_tlast;      // frame_end
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  floyd_steinberg_dither_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  logic [BUS_W-1:0] pixel_q[$];          // pixels waiting to be offered
  dithered_t        dither_q[$];         // predicted results, oldest first
  int               errors = 0;
  int               cycle_count = 0;
  int               items_sent = 0;
  bit               calm = 1'b0;         // no idling on either side
  bit               in_taken = 1'b0;     // transaction on in_ at the last rising edge
  int               tx_gap = 0;
  int               rx_gap = 0;
  int               rx_hold = 0;
  int               hold_id = 0;         // bumped to ask the receiver for a long hold-off
  int               hold_seen = 0;

  // register copies seen by the predictor
  logic [LV_W-1:0]    cur_levels = LV_RESET;
  logic [IMG_W_W-1:0] cur_width  = WIDTH_RESET;
  logic [IMG_H_W-1:0] cur_height = HEIGHT_RESET;

  // diffusion state of the predictor
  err_t err_row   [MAX_WIDTH][CH_N];     // errors owed to the next row, per column
  err_t carry_right[CH_N];               // 7/16 share for the pixel to the right
  err_t below_acc [2][CH_N];             // partial sums under the current and next column
  int   col_pos = 0;
  int   row_pos = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report(input string msg);
    begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // predictor: one pixel through error diffusion
  // --------------------------------------------------------------------------
  task automatic dither_pixel(input logic [BUS_W-1:0] px, output dithered_t res);
    int lv, w, h, x, v, n, mag, r, q, e, s3, s5, s1;
    bit last_col, last_row;
    begin
      // out of range register values fold onto the nearest meaningful one
      lv = int'(cur_levels);
      if (lv < 1) lv = 1;
      if (lv > 256) lv = 256;
      w = int'(cur_width);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(cur_height);
      if (h < 1) h = 1;
      x = col_pos;
      if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;

      // frame start wipes the whole row store, row start the local sums
      if (x == 0 && row_pos == 0) begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
          for (int c = 0; c < CH_N; c++) err_row[i][c] = '0;
        end
      end
      if (x == 0) begin
        for (int c = 0; c < CH_N; c++) begin
          carry_right[c] = '0;
          below_acc[0][c] = '0;
          below_acc[1][c] = '0;
        end
      end

      // a position past the end (size shrunk mid-frame) closes row or frame
      last_col = (x + 1 >= w);
      last_row = (row_pos + 1 >= h);

      for (int c = 0; c < CH_N; c++) begin
        v = int'(px[c*PIX_W +: PIX_W]) + int'(carry_right[c]) + int'(err_row[x][c]);
        if (v < V_MIN) v = V_MIN;
        if (v > V_MAX) v = V_MAX;
        // round half away from zero, then scale by the step
        n = lv * v;
        mag = (n < 0) ? -n : n;
        r = (2 * mag + 255) / 510;
        if (n < 0) r = -r;
        q = r * (255 / lv);
        e = v - q;
        if (q < 0) res.rgb[c*PIX_W +: PIX_W] = '0;
        else if (q > 255) res.rgb[c*PIX_W +: PIX_W] = 8'hFF;
        else res.rgb[c*PIX_W +: PIX_W] = q[PIX_W-1:0];

        // shares truncate toward zero; those falling off the image are dropped
        carry_right[c] = last_col ? err_t'(0) : err_t'((e * 7) / 16);
        s3 = (last_row || x == 0) ? 0 : (e * 3) / 16;
        s5 = last_row ? 0 : (e * 5) / 16;
        s1 = (last_row || last_col) ? 0 : e / 16;

        if (x > 0) err_row[x-1][c] = err_t'(int'(below_acc[0][c]) + s3);
        below_acc[0][c] = err_t'(int'(below_acc[1][c]) + s5);
        below_acc[1][c] = err_t'(s1);
        if (last_col) err_row[x][c] = below_acc[0][c];
      end
      res.frame_end = last_col && last_row;

      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos = x + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // input side: predict at each transaction, offer the next pixel on the
  // falling edge, idle in random bursts between transactions
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dithered_t pred;
    if (in_tvalid && in_tready) begin
      dither_pixel(in_tdata, pred);
      dither_q.push_back(pred);
    end
    in_taken <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    // valid may only drop once the offered pixel has been taken
    if (!in_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap--;
      end else if (pixel_q.size() > 0) begin
        in_tdata <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output side: ready with random stall bursts and one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_id) begin
      hold_seen = hold_id;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 16);
    end
  end

  // checker: each result transaction against the oldest prediction
  always @(posedge clk) begin
    dithered_t want;
    if (out_tvalid && out_tready) begin
      if (dither_q.size() == 0) begin
        report($sformatf("result %h last %b with nothing expected", out_tdata, out_tlast));
      end else begin
        want = dither_q.pop_front();
        if (out_tdata[0 +: PIX_W] !== want.rgb[0 +: PIX_W])
          report($sformatf("red_out %0d, expected %0d",
                           out_tdata[0 +: PIX_W], want.rgb[0 +: PIX_W]));
        if (out_tdata[PIX_W +: PIX_W] !== want.rgb[PIX_W +: PIX_W])
          report($sformatf("green_out %0d, expected %0d",
                           out_tdata[PIX_W +: PIX_W], want.rgb[PIX_W +: PIX_W]));
        if (out_tdata[2*PIX_W +: PIX_W] !== want.rgb[2*PIX_W +: PIX_W])
          report($sformatf("blue_out %0d, expected %0d",
                           out_tdata[2*PIX_W +: PIX_W], want.rgb[2*PIX_W +: PIX_W]));
        if (out_tlast !== want.frame_end)
          report($sformatf("frame_end %b, expected %b", out_tlast, want.frame_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencing helpers
  // --------------------------------------------------------------------------
  // every pixel taken and every result out; leaves us just past a rising edge
  task automatic wait_idle();
    begin
      do begin
        @(posedge clk);
        #1;
      end while (!(pixel_q.size() == 0 && !in_tvalid && dither_q.size() == 0));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr <= idx;
      cfg_wdata <= val;
      case (idx)
        CFG_LEVELS: cur_levels = val[LV_W-1:0];
        CFG_WIDTH:  cur_width  = val[IMG_W_W-1:0];
        CFG_HEIGHT: cur_height = val[IMG_H_W-1:0];
        default: ;
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b0;
    end
  endtask

  // move to a point in the cycle where the queue can be filled without a race
  task automatic open_batch();
    begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic push_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    begin
      pixel_q.push_back({b, g, r});
      items_sent++;
    end
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int ew, eh, count, phase, lv;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: levels 1 on a 640 wide frame, a few pixels into row 0
    open_batch();
    push_px(8'h00, 8'h00, 8'h00);
    push_px(8'hFF, 8'hFF, 8'hFF);
    push_px(8'h00, 8'hFF, 8'h00);
    push_px(8'h80, 8'h7F, 8'h81);
    wait_idle();

    // shrink the width mid-row: column past the end closes the row;
    // levels 256 has step zero so everything goes to error
    write_reg(CFG_WIDTH, 16'd3);
    write_reg(CFG_LEVELS, 16'd256);
    open_batch();
    push_px(8'hFF, 8'h01, 8'h80);
    push_px(8'hFF, 8'hFF, 8'hFF);
    push_px(8'h7F, 8'h00, 8'hFE);
    wait_idle();

    // two levels on a 2x2 image, five pixels with saturating neighbours
    write_reg(CFG_LEVELS, 16'd2);
    write_reg(CFG_WIDTH, 16'd2);
    write_reg(CFG_HEIGHT, 16'd2);
    open_batch();
    push_px(8'hFF, 8'h00, 8'h40);
    push_px(8'hFF, 8'h00, 8'hC0);
    push_px(8'h00, 8'hFF, 8'h60);
    push_px(8'hFF, 8'hFF, 8'h00);
    push_px(8'h00, 8'h00, 8'hFF);
    wait_idle();

    // zero registers fold to one: every pixel is a whole frame
    write_reg(CFG_LEVELS, 16'd0);
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);      // undecoded index, no effect
    open_batch();
    push_px(8'h7F, 8'h80, 8'hFF);
    push_px(8'h00, 8'hFF, 8'h01);
    wait_idle();

    // oversized registers clip: widest row, tallest frame, step zero
    write_reg(CFG_LEVELS, 16'hFFFF);
    write_reg(CFG_WIDTH, 16'hFFFF);
    write_reg(CFG_HEIGHT, 16'hFFFF);
    open_batch();
    push_px(8'hFF, 8'hFF, 8'hFF);
    push_px(8'h00, 8'h00, 8'h00);
    push_px(8'hAA, 8'h55, 8'hFF);
    wait_idle();

    // top bins at large levels, then back to a tiny image mid-row
    write_reg(CFG_LEVELS, 16'd255);
    write_reg(CFG_WIDTH, 16'd1);
    open_batch();
    push_px(8'hFF, 8'hFE, 8'h01);
    push_px(8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    // random phases: mostly whole frames of a small image, sometimes cut short
    phase = 0;
    while (items_sent < TARGET_PIX) begin
      if (items_sent >= CALM_PIX) calm = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       lv = 1;
          1:       lv = 256;
          2:       lv = 2;
          3:       lv = $urandom_range(257, 511);
          4:       lv = 0;
          default: lv = $urandom_range(1, 255);
        endcase
        write_reg(CFG_LEVELS, {7'($urandom), 9'(lv)});
      end
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 15) == 0)
          write_reg(CFG_WIDTH, {5'($urandom), 11'(MAX_WIDTH)});
        else
          write_reg(CFG_WIDTH, {5'($urandom), 11'($urandom_range(1, 8))});
      end
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 15) == 0) write_reg(CFG_HEIGHT, 16'hFFFF);
        else write_reg(CFG_HEIGHT, 16'($urandom_range(1, 5)));
      end
      if ($urandom_range(0, 19) == 0) write_reg(CFG_SPARE, 16'($urandom));

      ew = int'(cur_width);
      if (ew < 1) ew = 1;
      if (ew > MAX_WIDTH) ew = MAX_WIDTH;
      eh = int'(cur_height);
      if (eh < 1) eh = 1;
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, 20);
      else if (ew * eh <= 48) count = ew * eh;
      else count = $urandom_range(8, 40);

      open_batch();
      // one phase runs against a receiver that holds off for a long time
      if (phase == 3) hold_id++;
      for (int i = 0; i < count; i++) push_px(rand_chan(), rand_chan(), rand_chan());
      // the sender waits for every result before touching the registers
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && dither_q.size() == 0) begin
      $display("floyd_steinberg_dither_core_tb: PASS");
    end else begin
      $display("floyd_steinberg_dither_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("floyd_steinberg_dither_core_tb: FAIL");
    $finish;
  end

endmodule
